FILE: sv/sorted_frame_flag_table_macros.svh
// Assertion macros shared by the sorted frame flag table RTL.
`ifndef SORTED_FRAME_FLAG_TABLE_MACROS_SVH
`define SORTED_FRAME_FLAG_TABLE_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define SFFT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the usual clk_i / rst_ni pair of the enclosing module.
`define SFFT_ASSERT(lbl, prop, msg) \
  `SFFT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/sfft_pkg.sv
// Types, codes and default values for the sorted frame flag table.
package sfft_pkg;

  // Default sizing and flag bit positions.
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned StartBitDef   = 0;
  localparam int unsigned EndBitDef     = 1;

  // Field widths of the request and result items.
  localparam int unsigned ModeW     = 2;
  localparam int unsigned FrameW    = 16;
  localparam int unsigned FlagsW    = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned MarkW     = 17;
  localparam int unsigned EntCntW   = 7;
  localparam int unsigned InDataW   = FrameW + FlagsW;
  localparam int unsigned OutDataW  = FlagsW + FrameW + MarkW + EntCntW;

  // Configuration port.
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam logic [CfgIdxW-1:0] CfgMotionActive = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameCount   = 2'd1;

  // Request modes; the unused code behaves as a read.
  localparam logic [ModeW-1:0] ModeRead       = 2'd0;
  localparam logic [ModeW-1:0] ModeWrite      = 2'd1;
  localparam logic [ModeW-1:0] ModeResetMarks = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusInactive = 2'd1;
  localparam logic [StatusW-1:0] StatusFull     = 2'd2;

  // One table entry as held in memory.
  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [FlagsW-1:0] flags;
  } entry_t;

endpackage

FILE: sv/sorted_frame_flag_table.sv
// Sorted (frame, flags) table held in a synchronous memory, with start and end marks.
// Steps: a linear search reads entries until the first frame not below the key; a remove
// or insert then moves the later entries one place, an insert or replace stores the entry,
// and the marks and result are updated last. Inactive requests go straight to the result.
// Throughput: one request at a time, and a stalled result holds back the next request; the
// entry memory has a single read and a single write port.
// Reset: entry count and start mark clear, end mark becomes -1; memory is not cleared.
`include "sorted_frame_flag_table_macros.svh"

module sorted_frame_flag_table #(
  parameter int unsigned MAX_ENTRIES = sfft_pkg::MaxEntriesDef,
  parameter int unsigned START_BIT   = sfft_pkg::StartBitDef,
  parameter int unsigned END_BIT     = sfft_pkg::EndBitDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfft_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sfft_pkg::CfgDataW-1:0]   cfg_data_i,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sfft_pkg::InDataW-1:0]    s_axis_tdata,  // frame[15:0], new_flags[47:16]
  input  logic [sfft_pkg::ModeW-1:0]      s_axis_tuser,  // mode[1:0]
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sfft_pkg::OutDataW-1:0]   m_axis_tdata,  // found_flags[31:0],
                                                         // left_mark_out[47:32],
                                                         // right_mark_out[64:48],
                                                         // entry_count[71:65]
  output logic [sfft_pkg::StatusW-1:0]    m_axis_tuser   // status[1:0]
);

  import sfft_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_DEL,
    ST_INS,
    ST_PUT,
    ST_FIN
  } state_e;

  // Control and payload registers.
  state_e                   state_q, state_d;
  logic                     motion_active_q, motion_active_d;
  logic [FrameW-1:0]        frame_count_q, frame_count_d;
  logic [ModeW-1:0]         mode_q, mode_d;
  logic [FrameW-1:0]        frame_q, frame_d;
  logic [FlagsW-1:0]        flags_q, flags_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic [CW-1:0]            k_q, k_d;
  logic                     rd_pend_q, rd_pend_d;
  logic                     hit_q, hit_d;
  logic [FlagsW-1:0]        found_q, found_d;
  logic                     full_q, full_d;
  logic                     inactive_q, inactive_d;
  logic [CW-1:0]            used_q, used_d;
  logic [FrameW-1:0]        start_q, start_d;
  logic signed [MarkW-1:0]  end_q, end_d;
  logic                     out_valid_q, out_valid_d;
  logic [StatusW-1:0]       out_status_q, out_status_d;
  logic [FlagsW-1:0]        out_found_q, out_found_d;
  logic [FrameW-1:0]        out_left_q, out_left_d;
  logic [MarkW-1:0]         out_right_q, out_right_d;
  logic [EntCntW-1:0]       out_count_q, out_count_d;

  // Entry memory ports.
  entry_t                   mem_q [MAX_ENTRIES];
  entry_t                   rdata_q;
  logic                     mem_re, mem_we;
  logic [AW-1:0]            raddr, waddr;
  entry_t                   wdata;

  // Helpers.
  logic                     in_acc;
  logic [CW-1:0]            k_nx, k_nx1;
  logic signed [MarkW-1:0]  fc_m1;
  logic                     apply;
  logic [CW+EntCntW-1:0]    cnt_ext;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fc_m1         = $signed({1'b0, frame_count_q}) - MarkW'(1);
  assign cnt_ext       = {{EntCntW{1'b0}}, used_q};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_count_q, out_right_q, out_left_q, out_found_q};

  // Next-state logic: search, shift, write back and result.
  always_comb begin
    state_d         = state_q;
    motion_active_d = motion_active_q;
    frame_count_d   = frame_count_q;
    mode_d          = mode_q;
    frame_d         = frame_q;
    flags_d         = flags_q;
    pos_d           = pos_q;
    k_d             = k_q;
    rd_pend_d       = rd_pend_q;
    hit_d           = hit_q;
    found_d         = found_q;
    full_d          = full_q;
    inactive_d      = inactive_q;
    used_d          = used_q;
    start_d         = start_q;
    end_d           = end_q;
    out_valid_d     = out_valid_q && !m_axis_tready;
    out_status_d    = out_status_q;
    out_found_d     = out_found_q;
    out_left_d      = out_left_q;
    out_right_d     = out_right_q;
    out_count_d     = out_count_q;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    raddr           = '0;
    waddr           = '0;
    wdata           = '0;
    k_nx            = k_q;
    k_nx1           = k_q;
    apply           = 1'b0;

    // Configuration registers.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMotionActive: motion_active_d = cfg_data_i[0];
        CfgFrameCount:   frame_count_d   = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_d     = s_axis_tuser;
          frame_d    = s_axis_tdata[FrameW-1:0];
          flags_d    = s_axis_tdata[InDataW-1:FrameW];
          pos_d      = '0;
          rd_pend_d  = 1'b0;
          hit_d      = 1'b0;
          found_d    = '0;
          full_d     = 1'b0;
          inactive_d = !motion_active_q;
          state_d    = motion_active_q ? ST_SCAN : ST_FIN;
        end
      end

      // Linear search for the first entry whose frame is not below the key.
      ST_SCAN: begin
        if (!rd_pend_q) begin
          if (pos_q == used_q) begin
            state_d = ST_EXEC;
          end else begin
            mem_re    = 1'b1;
            raddr     = pos_q[AW-1:0];
            rd_pend_d = 1'b1;
          end
        end else if (rdata_q.frame < frame_q) begin
          pos_d = pos_q + CW'(1);
          if (pos_d == used_q) begin
            rd_pend_d = 1'b0;
            state_d   = ST_EXEC;
          end else begin
            mem_re = 1'b1;
            raddr  = pos_d[AW-1:0];
          end
        end else begin
          rd_pend_d = 1'b0;
          hit_d     = (rdata_q.frame == frame_q);
          found_d   = (rdata_q.frame == frame_q) ? rdata_q.flags : '0;
          state_d   = ST_EXEC;
        end
      end

      // Choose between replace, remove, insert or no table change.
      ST_EXEC: begin
        state_d   = ST_FIN;
        rd_pend_d = 1'b0;
        if (mode_q == ModeWrite) begin
          if (hit_q) begin
            if (flags_q != '0) begin
              state_d = ST_PUT;
            end else begin
              k_d     = pos_q;
              state_d = ST_DEL;
            end
          end else if (flags_q != '0) begin
            if (used_q >= MaxCount) begin
              full_d = 1'b1;
            end else begin
              k_d     = used_q;
              state_d = ST_INS;
            end
          end
        end
      end

      // Remove: move each later entry down one place.
      ST_DEL: begin
        if (rd_pend_q) begin
          mem_we = 1'b1;
          waddr  = k_q[AW-1:0];
          wdata  = rdata_q;
          k_nx   = k_q + CW'(1);
        end
        k_d   = k_nx;
        k_nx1 = k_nx + CW'(1);
        if (k_nx1 < used_q) begin
          mem_re    = 1'b1;
          raddr     = k_nx1[AW-1:0];
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          used_d    = used_q - CW'(1);
          state_d   = ST_FIN;
        end
      end

      // Insert: move each entry from the insert point up one place, top first.
      ST_INS: begin
        if (rd_pend_q) begin
          mem_we = 1'b1;
          waddr  = k_q[AW-1:0];
          wdata  = rdata_q;
          k_nx   = k_q - CW'(1);
        end
        k_d   = k_nx;
        k_nx1 = k_nx - CW'(1);
        if (k_nx > pos_q) begin
          mem_re    = 1'b1;
          raddr     = k_nx1[AW-1:0];
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          state_d   = ST_PUT;
        end
      end

      // Write the new or replaced entry at the search position.
      ST_PUT: begin
        mem_we      = 1'b1;
        waddr       = pos_q[AW-1:0];
        wdata.frame = frame_q;
        wdata.flags = flags_q;
        if (!hit_q) begin
          used_d = used_q + CW'(1);
        end
        state_d = ST_FIN;
      end

      // Update the marks and hand the result to the output register.
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          apply = !inactive_q && (mode_q == ModeWrite) && !full_q;
          if (!inactive_q && (mode_q == ModeResetMarks)) begin
            start_d = '0;
            end_d   = fc_m1;
          end
          if (apply && flags_q[START_BIT]) begin
            start_d = frame_q;
            if ($signed({1'b0, start_d}) > end_d) begin
              end_d = fc_m1;
            end
          end
          if (apply && flags_q[END_BIT]) begin
            end_d = $signed({1'b0, frame_q});
            if ($signed({1'b0, start_d}) > end_d) begin
              start_d = '0;
            end
          end
          out_valid_d  = 1'b1;
          out_status_d = inactive_q ? StatusInactive : (full_q ? StatusFull : StatusOk);
          out_found_d  = (inactive_q || full_q) ? '0 : found_q;
          out_left_d   = start_d;
          out_right_d  = end_d;
          out_count_d  = cnt_ext[EntCntW-1:0];
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      motion_active_q <= 1'b0;
      frame_count_q   <= '0;
      rd_pend_q       <= 1'b0;
      used_q          <= '0;
      start_q         <= '0;
      end_q           <= '1;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      motion_active_q <= motion_active_d;
      frame_count_q   <= frame_count_d;
      rd_pend_q       <= rd_pend_d;
      used_q          <= used_d;
      start_q         <= start_d;
      end_q           <= end_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // Payload registers of the request in progress and of the result.
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    frame_q      <= frame_d;
    flags_q      <= flags_d;
    pos_q        <= pos_d;
    k_q          <= k_d;
    hit_q        <= hit_d;
    found_q      <= found_d;
    full_q       <= full_d;
    inactive_q   <= inactive_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_left_q   <= out_left_d;
    out_right_q  <= out_right_d;
    out_count_q  <= out_count_d;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // The entry count never exceeds the table size.
  `SFFT_ASSERT(a_used_bound, used_q <= MaxCount, "entry count above table size")
  // Shifts never read and write the same entry in one cycle.
  `SFFT_ASSERT(a_no_rw_clash, (mem_we && mem_re) |-> (waddr != raddr), "read/write clash")
  // The entry count moves by at most one per request step.
  `SFFT_ASSERT(a_used_step,
      (used_q != $past(used_q)) |-> ((used_q == $past(used_q) + CW'(1)) ||
                                     (used_q == $past(used_q) - CW'(1))),
      "entry count jumped")
  // The memory is only written while a table change is in progress.
  `SFFT_ASSERT(a_we_state,
      mem_we |-> ((state_q == ST_DEL) || (state_q == ST_INS) || (state_q == ST_PUT)),
      "memory write outside an update")
  // A new result appears only after the final step of a request.
  `SFFT_ASSERT(a_result_src, $rose(out_valid_q) |-> ($past(state_q) == ST_FIN),
      "result without a finished request")

endmodule

FILE: tb/tb_sorted_frame_flag_table.sv
// Self-checking testbench for the sorted frame flag table, with directed and random requests.
module tb_sorted_frame_flag_table;
  import sfft_pkg::*;

  localparam int unsigned TableDepth  = MaxEntriesDef;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 2 * TableDepth + 8;

  // The spare mode code, which the block treats as a read.
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  // Flag words that move only the start or only the end mark.
  localparam logic [FlagsW-1:0] StartFlag = FlagsW'(1) << StartBitDef;
  localparam logic [FlagsW-1:0] EndFlag   = FlagsW'(1) << EndBitDef;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [FlagsW-1:0]  found;
    logic [FrameW-1:0]  left_mark;
    logic [MarkW-1:0]   right_mark;
    logic [EntCntW-1:0] count;
  } table_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i   = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata  = '0;
  logic [ModeW-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [StatusW-1:0]    m_axis_tuser;

  // Idle rates in percent for the request and result sides.
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  table_result_t pending_results[$];

  // Local copy of the table, the marks and the registers.
  logic [FrameW-1:0] model_frames [TableDepth];
  logic [FlagsW-1:0] model_flags  [TableDepth];
  int unsigned       model_held   = 0;
  int                model_start  = 0;
  int                model_end    = -1;
  logic              model_motion = 1'b0;
  logic [FrameW-1:0] model_slots  = '0;

  sorted_frame_flag_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a period of ten time units.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The run is abandoned if it goes on far longer than any correct run could.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // The result side stalls at random.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Moves one mark to the frame; if the marks cross, the other one is reset.
  function automatic void move_mark(logic [FrameW-1:0] frame, bit to_end);
    if (to_end) begin
      model_end = int'(frame);
    end else begin
      model_start = int'(frame);
    end
    if (model_start > model_end) begin
      if (to_end) begin
        model_start = 0;
      end else begin
        model_end = int'(model_slots) - 1;
      end
    end
  endfunction

  // Applies one accepted request to the local table and queues the result it must give.
  function automatic void predict_table_op(logic [ModeW-1:0] mode, logic [FrameW-1:0] frame,
                                           logic [FlagsW-1:0] flags);
    table_result_t want;
    int unsigned   pos;
    int unsigned   k;
    bit            hit;
    want.status = StatusOk;
    want.found  = '0;
    if (!model_motion) begin
      want.status = StatusInactive;
    end else begin
      pos = 0;
      while (pos < model_held && model_frames[pos] < frame) pos++;
      hit = (pos < model_held) && (model_frames[pos] == frame);
      if (hit) want.found = model_flags[pos];
      if (mode == ModeResetMarks) begin
        model_start = 0;
        model_end   = int'(model_slots) - 1;
      end else if (mode == ModeWrite) begin
        if (hit && flags != '0) begin
          model_flags[pos] = flags;
        end else if (hit) begin
          // Removal closes the gap by moving later entries down.
          for (k = pos; k + 1 < model_held; k++) begin
            model_frames[k] = model_frames[k + 1];
            model_flags[k]  = model_flags[k + 1];
          end
          model_held--;
        end else if (flags != '0 && model_held >= TableDepth) begin
          want.status = StatusFull;
          want.found  = '0;
        end else if (flags != '0) begin
          // Insertion opens a slot by moving later entries up.
          for (k = model_held; k > pos; k--) begin
            model_frames[k] = model_frames[k - 1];
            model_flags[k]  = model_flags[k - 1];
          end
          model_frames[pos] = frame;
          model_flags[pos]  = flags;
          model_held++;
        end
        if (want.status == StatusOk) begin
          if (flags[StartBitDef]) move_mark(frame, 1'b0);
          if (flags[EndBitDef]) move_mark(frame, 1'b1);
        end
      end
    end
    want.left_mark  = model_start[FrameW-1:0];
    want.right_mark = model_end[MarkW-1:0];
    want.count      = model_held[EntCntW-1:0];
    pending_results.push_back(want);
  endfunction

  // Each result is compared field by field with the oldest expectation.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[31:0] !== want.found)
          report_mismatch("found_flags", m_axis_tdata[31:0], want.found);
        if (m_axis_tdata[47:32] !== want.left_mark)
          report_mismatch("left_mark_out", 32'(m_axis_tdata[47:32]), 32'(want.left_mark));
        if (m_axis_tdata[64:48] !== want.right_mark)
          report_mismatch("right_mark_out", 32'(m_axis_tdata[64:48]), 32'(want.right_mark));
        if (m_axis_tdata[71:65] !== want.count)
          report_mismatch("entry_count", 32'(m_axis_tdata[71:65]), 32'(want.count));
      end
    end
  end

  // Sends one request, with random gaps before it, and predicts its result on acceptance.
  task automatic send_request(logic [ModeW-1:0] mode, logic [FrameW-1:0] frame,
                              logic [FlagsW-1:0] flags);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {flags, frame};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_table_op(mode, frame, flags);
  endtask

  // Every request gives exactly one result, so the block is idle once the queue is empty.
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] value);
    wait_for_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (index == CfgMotionActive) begin
      model_motion = value[0];
    end else if (index == CfgFrameCount) begin
      model_slots = value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // With no motion selected every mode is refused.
  task automatic test_inactive_motion();
    send_request(ModeRead, 16'd0, '0);
    send_request(ModeWrite, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(ModeResetMarks, 16'd5, '0);
    send_request(ModeUnused, 16'd9, 32'h1);
  endtask

  // Insert, replace, read, remove and the spare mode on a small table.
  task automatic test_basic_edits();
    write_register(CfgMotionActive, 16'd1);
    write_register(CfgFrameCount, 16'd100);
    send_request(ModeWrite, 16'd10, 32'h100);
    send_request(ModeRead, 16'd10, '0);
    send_request(ModeWrite, 16'd10, 32'hFFFF_FFFF);
    send_request(ModeRead, 16'd5, '0);
    send_request(ModeWrite, 16'd0, 32'h4);
    send_request(ModeWrite, 16'hFFFF, 32'h8);
    send_request(ModeUnused, 16'hFFFF, '0);
    send_request(ModeWrite, 16'd10, '0);
    send_request(ModeWrite, 16'd7, '0);
    send_request(ModeResetMarks, 16'd0, '0);
  endtask

  // Marks crossing each other, an empty frame range and requests refused mid-run.
  task automatic test_mark_crossing();
    write_register(CfgFrameCount, 16'd0);
    send_request(ModeWrite, 16'd50, StartFlag);
    send_request(ModeWrite, 16'd20, EndFlag);
    send_request(ModeWrite, 16'd30, StartFlag);
    send_request(ModeResetMarks, 16'hFFFF, '0);
    write_register(CfgMotionActive, 16'd0);
    send_request(ModeRead, 16'd50, '0);
    send_request(ModeWrite, 16'd60, StartFlag | EndFlag);
    write_register(CfgMotionActive, 16'd1);
    write_register(CfgFrameCount, 16'hFFFF);
    send_request(ModeWrite, 16'hFFFF, StartFlag);
  endtask

  // Fills the table, then tries an insert that must be refused, then drains part of it.
  task automatic test_full_table();
    int unsigned i;
    i = 0;
    while (model_held < TableDepth) begin
      send_request(ModeWrite, FrameW'(40063 - i), $urandom | 32'h100);
      i++;
    end
    send_request(ModeWrite, 16'd12345, 32'h5);
    send_request(ModeRead, 16'd12345, '0);
    send_request(ModeWrite, 16'd40063, 32'hF0);
    send_request(ModeWrite, 16'd12345, '0);
    send_request(ModeWrite, 16'd40063, '0);
    send_request(ModeWrite, 16'd12345, 32'h3);
    for (i = 0; i < 40; i++) begin
      send_request(ModeWrite, FrameW'(40062 - i), '0);
    end
  endtask

  // Random requests, mostly on a small window of frames so that hits and removals are common.
  task automatic test_random_traffic(int unsigned n_items, int unsigned key_base);
    logic [ModeW-1:0]  mode;
    logic [FrameW-1:0] frame;
    logic [FlagsW-1:0] flags;
    int unsigned       pick;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        mode = ModeWrite;
      end else if (pick < 80) begin
        mode = ModeRead;
      end else if (pick < 92) begin
        mode = ModeResetMarks;
      end else begin
        mode = ModeUnused;
      end
      if ($urandom_range(99) < 85) begin
        frame = FrameW'(key_base + $urandom_range(60));
      end else begin
        frame = FrameW'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 25) begin
        flags = '0;
      end else if (pick < 55) begin
        flags = FlagsW'($urandom_range(3));
        if ($urandom_range(1)) flags = flags | ($urandom & 32'hFFFF_FFFC);
      end else begin
        flags = $urandom;
      end
      send_request(mode, frame, flags);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct   = 16;
    recv_stall_pct = 64;
    test_inactive_motion();
    test_basic_edits();
    test_mark_crossing();
    test_full_table();

    write_register(CfgFrameCount, CfgDataW'($urandom_range(1, 200)));
    test_random_traffic(130, 0);

    wait_for_results();
    send_gap_pct   = 64;
    recv_stall_pct = 16;
    write_register(CfgFrameCount, 16'd0);
    test_random_traffic(130, 0);

    wait_for_results();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_register(CfgFrameCount, 16'hFFFF);
    test_random_traffic(110, 65475);

    // Let any stray result show itself before the verdict.
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
